FILE: design/tcc_pkg.sv
// Shared constants, codes and controller/datapath types for the text console
// cursor engine. No dependencies; every other design file but tcc_ram imports this package.
package tcc_pkg;

   // Screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int BOTTOM  = COLUMNS * (ROWS - 1);

   // Field widths
   localparam int FUNC_W = 1;
   localparam int CHAR_W = 8;
   localparam int CUR_W  = 11;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int SCAN_W = $clog2(CELLS + 1);

   // Cell index constants at cursor width
   localparam logic [CUR_W-1:0] CELL_LAST   = CUR_W'(CELLS - 1);
   localparam logic [CUR_W-1:0] BOTTOM_CELL = CUR_W'(BOTTOM);
   localparam logic [CUR_W:0]   CELLS_EXT   = (CUR_W + 1)'(CELLS);
   localparam logic [CUR_W:0]   COLUMNS_EXT = (CUR_W + 1)'(COLUMNS);

   // Sweep counter limits
   localparam logic [SCAN_W-1:0] SCAN_CELLS  = SCAN_W'(CELLS);
   localparam logic [SCAN_W-1:0] SCAN_LAST   = SCAN_W'(CELLS - 1);
   localparam logic [SCAN_W-1:0] SCAN_BOTTOM = SCAN_W'(BOTTOM);

   // Function codes
   localparam logic [FUNC_W-1:0] FUNC_PUT  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;

   // Control codes
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;

   // Datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_CLEAR,
      OP_EXEC,
      OP_TAB2,
      OP_SWEEP,
      OP_LOAD
   } tcc_op_type;

   typedef struct packed {
      tcc_op_type op;
   } tcc_cmd_type;

   typedef struct packed {
      logic is_tab;       // offered transaction is a tab put
      logic exec_scroll;  // offered transaction scrolls in its first step
      logic tab_scroll;   // tab second step scrolls
      logic clear_last;   // reset clearing pass at its last cell
      logic sweep_last;   // scroll sweep at its last step
   } tcc_status_type;

endpackage

FILE: design/tcc_chan_if.sv
// Valid/ready channel interfaces for the put/read requests and their responses.
// Depends on tcc_pkg for field widths.
interface tcc_req_if import tcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [CHAR_W-1:0] char_code;
   logic [CUR_W-1:0]  read_cell;

   modport source (output valid, output func, output char_code, output read_cell,
                   input ready);
   modport sink   (input valid, input func, input char_code, input read_cell,
                   output ready);
endinterface

interface tcc_rsp_if import tcc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CUR_W-1:0]  cursor_cell;
   logic [CHAR_W-1:0] read_data;
   logic              scrolled;

   modport source (output valid, output cursor_cell, output read_data, output scrolled,
                   input ready);
   modport sink   (input valid, input cursor_cell, input read_data, input scrolled,
                   output ready);
endinterface

FILE: design/tcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcc_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tcc_ctrl.sv
// Controller state machine: reset clearing pass, item sequencing, scroll sweep
// and the response handshake. Depends on tcc_pkg.
module tcc_ctrl import tcc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  tcc_status_type status,
   output tcc_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TAB2,
      ST_SWEEP,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd.op       = OP_IDLE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_EXEC;
               priority if (status.is_tab) begin
                  state_in = ST_TAB2;
               end else if (status.exec_scroll) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_RESPOND;
               end
            end
         end
         ST_TAB2: begin
            cmd.op   = OP_TAB2;
            state_in = status.tab_scroll ? ST_SWEEP : ST_RESPOND;
         end
         ST_SWEEP: begin
            cmd.op = OP_SWEEP;
            if (status.sweep_last) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            // hold until the output register is free or being emptied
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_LOAD;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_rsp_from_respond: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESPOND)
      else $error("response raised outside the respond step");

   a_sweep_to_respond: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && status.sweep_last) |=> state_ff == ST_RESPOND)
      else $error("scroll sweep did not finish into the respond step");
`endif

endmodule

FILE: design/tcc_datapath.sv
// Datapath: screen store, cursor and row-start registers, sweep counter and the
// response payload register. Depends on tcc_pkg and tcc_ram.
module tcc_datapath import tcc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  tcc_cmd_type       cmd,
   output tcc_status_type    status,
   input  logic [FUNC_W-1:0] req_func,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [CUR_W-1:0]  req_read_cell,
   output logic [CUR_W-1:0]  rsp_cursor_cell,
   output logic [CHAR_W-1:0] rsp_read_data,
   output logic              rsp_scrolled
);

   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [CUR_W-1:0]  row_ff, row_in;
   logic [SCAN_W-1:0] scan_ff, scan_in;
   logic              scrolled_ff, scrolled_in;
   logic              read_item_ff, read_item_in;
   logic              read_hit_ff, read_hit_in;
   logic              copy_ff, copy_in;
   logic [CUR_W-1:0]  rsp_cursor_ff, rsp_cursor_in;
   logic [CHAR_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [CHAR_W-1:0] wr_data, rd_data;

   logic [CUR_W:0] cur_plus1, cur_plus2, row_next;
   logic           is_put, is_nl, is_bs, is_tab, is_plain;
   logic           scan_copy;

   assign cur_plus1 = {1'b0, cursor_ff} + (CUR_W + 1)'(1);
   assign cur_plus2 = {1'b0, cursor_ff} + (CUR_W + 1)'(2);
   assign row_next  = {1'b0, row_ff} + COLUMNS_EXT;

   assign is_put   = (req_func == FUNC_PUT);
   assign is_nl    = is_put && (req_char_code == CODE_NEWLINE);
   assign is_bs    = is_put && (req_char_code == CODE_BACKSPACE);
   assign is_tab   = is_put && (req_char_code == CODE_TAB);
   assign is_plain = is_put && !is_nl && !is_bs && !is_tab;

   assign scan_copy = (scan_ff < SCAN_BOTTOM);

   assign status.is_tab      = is_tab;
   assign status.exec_scroll = (is_nl && row_ff == BOTTOM_CELL)
                               || (is_plain && cursor_ff == CELL_LAST);
   assign status.tab_scroll  = (cur_plus2 >= CELLS_EXT);
   assign status.clear_last  = (scan_ff == SCAN_LAST);
   assign status.sweep_last  = (scan_ff == SCAN_CELLS);

   always_comb begin
      cursor_in       = cursor_ff;
      row_in          = row_ff;
      scan_in         = scan_ff;
      scrolled_in     = scrolled_ff;
      read_item_in    = read_item_ff;
      read_hit_in     = read_hit_ff;
      copy_in         = copy_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      wr_en           = 1'b0;
      wr_addr         = ADDR_W'(cursor_ff);
      wr_data         = '0;
      rd_en           = 1'b0;
      rd_addr         = ADDR_W'(req_read_cell);
      unique case (cmd.op)
         OP_IDLE: begin
         end
         OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[ADDR_W-1:0];
            scan_in = scan_ff + SCAN_W'(1);
         end
         OP_EXEC: begin
            scan_in      = '0;
            scrolled_in  = 1'b0;
            read_item_in = (req_func == FUNC_READ);
            read_hit_in  = ({1'b0, req_read_cell} < CELLS_EXT);
            priority if (!is_put) begin
               rd_en = 1'b1;
            end else if (is_nl) begin
               if (row_ff == BOTTOM_CELL) begin
                  cursor_in   = BOTTOM_CELL;
                  scrolled_in = 1'b1;
               end else begin
                  cursor_in = row_next[CUR_W-1:0];
                  row_in    = row_next[CUR_W-1:0];
               end
            end else if (is_bs) begin
               // stop at cell zero, otherwise clear the previous cell
               if (cursor_ff != '0) begin
                  wr_en     = 1'b1;
                  wr_addr   = ADDR_W'(cursor_ff - CUR_W'(1));
                  cursor_in = cursor_ff - CUR_W'(1);
                  if (cursor_ff == row_ff) begin
                     row_in = row_ff - CUR_W'(COLUMNS);
                  end
               end
            end else if (is_tab) begin
               wr_en = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_data = req_char_code;
               if (cursor_ff == CELL_LAST) begin
                  cursor_in   = BOTTOM_CELL;
                  row_in      = BOTTOM_CELL;
                  scrolled_in = 1'b1;
               end else begin
                  cursor_in = cur_plus1[CUR_W-1:0];
                  if (cur_plus1 == row_next) begin
                     row_in = row_next[CUR_W-1:0];
                  end
               end
            end
         end
         OP_TAB2: begin
            scan_in = '0;
            // drop the clear of a cell beyond the screen
            wr_en   = (cur_plus1 < CELLS_EXT);
            wr_addr = ADDR_W'(cur_plus1);
            if (cur_plus2 >= CELLS_EXT) begin
               cursor_in   = BOTTOM_CELL;
               row_in      = BOTTOM_CELL;
               scrolled_in = 1'b1;
            end else begin
               cursor_in = cur_plus2[CUR_W-1:0];
               if (cur_plus2 >= row_next) begin
                  row_in = row_next[CUR_W-1:0];
               end
            end
         end
         OP_SWEEP: begin
            // read one row ahead, write the cell behind; zeros past the copy span
            rd_en   = scan_copy;
            rd_addr = ADDR_W'(scan_ff[ADDR_W-1:0] + ADDR_W'(COLUMNS));
            wr_en   = (scan_ff != '0);
            wr_addr = ADDR_W'(scan_ff - SCAN_W'(1));
            wr_data = copy_ff ? rd_data : '0;
            copy_in = scan_copy;
            scan_in = scan_ff + SCAN_W'(1);
         end
         OP_LOAD: begin
            rsp_cursor_in   = cursor_ff;
            rsp_data_in     = (read_item_ff && read_hit_ff) ? rd_data : '0;
            rsp_scrolled_in = scrolled_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff   <= '0;
         row_ff      <= '0;
         scan_ff     <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         cursor_ff   <= cursor_in;
         row_ff      <= row_in;
         scan_ff     <= scan_in;
         scrolled_ff <= scrolled_in;
      end
   end

   always_ff @(posedge clock) begin
      read_item_ff    <= read_item_in;
      read_hit_ff     <= read_hit_in;
      copy_ff         <= copy_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   tcc_ram #(
      .WIDTH  (CHAR_W),
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_cursor_cell = rsp_cursor_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_scrolled    = rsp_scrolled_ff;

`ifndef SYNTHESIS
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cursor_ff} < CELLS_EXT)
      else $error("cursor left the screen");

   a_cursor_in_row: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff >= row_ff) && ({1'b0, cursor_ff} < row_next))
      else $error("cursor outside its tracked row");

   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD && scrolled_ff) |-> cursor_ff == BOTTOM_CELL)
      else $error("scrolled response without cursor at bottom row start");
`endif

endmodule

FILE: design/text_console_cursor_engine.sv
// Top level of the text console cursor engine: controller plus datapath.
// Depends on tcc_pkg, tcc_chan_if, tcc_ctrl and tcc_datapath.
//
//   channel   | dir | handshake            | payload
//   ----------+-----+----------------------+---------------------------------------
//   req_chan  | in  | valid / ready        | func, char_code, read_cell
//   rsp_chan  | out | valid / ready        | cursor_cell, read_data, scrolled
//
// Steps: reads, backspace, newline and ordinary characters pass through an accept
//   step, then a response load; tab also has a step for its second cell clear, since
//   both clears go through the single write port of the screen RAM.
// A scroll adds a sweep that copies every row up through the one read and one write
//   port, then zeroes the bottom row.
// Reset: synchronous; a clearing pass over every cell zeroes the screen RAM while
//   req_chan.ready stays low.
// Stalls: a new transaction is accepted while a finished response waits in the
//   output register; its own response then holds until that register drains.
module text_console_cursor_engine import tcc_pkg::*; (
   input  logic clock,
   input  logic reset,
   tcc_req_if.sink   req_chan,
   tcc_rsp_if.source rsp_chan
);

   tcc_cmd_type    cmd;
   tcc_status_type status;

   // sequencing: clearing pass, item steps, scroll sweep, response handshake
   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // screen store, cursor tracking and response payload
   tcc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_chan.func),
      .req_char_code   (req_chan.char_code),
      .req_read_cell   (req_chan.read_cell),
      .rsp_cursor_cell (rsp_chan.cursor_cell),
      .rsp_read_data   (rsp_chan.read_data),
      .rsp_scrolled    (rsp_chan.scrolled)
   );

endmodule

FILE: dv/tb_text_console_cursor_engine.sv
`timescale 1ns / 100ps
// Self-checking testbench for text_console_cursor_engine: directed table, then random runs.
// Depends on tcc_pkg, the tcc_req_if / tcc_rsp_if channel interfaces and the block itself.
module tb_text_console_cursor_engine;
   import tcc_pkg::*;

   // Cycles with no transaction on either channel before the run is abandoned.
   localparam int WATCHDOG_LIMIT = 20000;
   // Cycles to keep watching once every response has arrived.
   localparam int DRAIN_CYCLES   = 10;
   localparam int PHASE_ITEMS    = 250;
   localparam int SCRIPT_ROWS    = 24;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] char_code;
      logic [CUR_W-1:0]  read_cell;
   } console_cmd_type;

   typedef struct packed {
      logic [CUR_W-1:0]  cursor_cell;
      logic [CHAR_W-1:0] read_data;
      logic              scrolled;
   } console_resp_type;

   // One line of the directed script: when 'known' is set the response is typed in,
   // otherwise it comes from the screen model.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] char_code;
      logic [CUR_W-1:0]  read_cell;
      logic              known;
      console_resp_type  want;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcc_req_if req_chan ();
   tcc_rsp_if rsp_chan ();

   text_console_cursor_engine i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Screen model state: character store and cursor, kept in step with accepted requests.
   logic [CHAR_W-1:0] screen_mem [CELLS];
   logic [CUR_W-1:0]  cur_pos;

   console_resp_type reports_due [$];

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int items_sent      = 0;
   int rsps_seen       = 0;
   int mismatches      = 0;
   int idle_cycles     = 0;
   int reads_seen      = 0;
   int reads_beyond    = 0;
   int scroll_count    = 0;
   int dropped_clears  = 0;

   // Directed script: reset state, extremes of every field, each control code,
   // backspace at the home cell, reads beyond the screen, tab across a row end.
   script_row_type directed_rows [SCRIPT_ROWS] = '{
      '{FUNC_READ, 8'h00,          11'd0,    1'b1, '{11'd0,  8'h00, 1'b0}},
      '{FUNC_READ, 8'h00,          11'd2047, 1'b1, '{11'd0,  8'h00, 1'b0}},
      '{FUNC_READ, 8'h00,          11'd1999, 1'b1, '{11'd0,  8'h00, 1'b0}},
      '{FUNC_READ, 8'hFF,          11'd2000, 1'b1, '{11'd0,  8'h00, 1'b0}},
      '{FUNC_PUT,  CODE_BACKSPACE, 11'h7FF,  1'b1, '{11'd0,  8'h00, 1'b0}},
      '{FUNC_PUT,  8'h41,          11'h000,  1'b1, '{11'd1,  8'h00, 1'b0}},
      '{FUNC_PUT,  8'hFF,          11'h555,  1'b1, '{11'd2,  8'h00, 1'b0}},
      '{FUNC_PUT,  8'h00,          11'h2AA,  1'b1, '{11'd3,  8'h00, 1'b0}},
      '{FUNC_READ, 8'h5A,          11'd0,    1'b1, '{11'd3,  8'h41, 1'b0}},
      '{FUNC_READ, 8'hA5,          11'd1,    1'b1, '{11'd3,  8'hFF, 1'b0}},
      '{FUNC_PUT,  CODE_TAB,       11'h7FF,  1'b1, '{11'd5,  8'h00, 1'b0}},
      '{FUNC_READ, 8'h00,          11'd3,    1'b1, '{11'd5,  8'h00, 1'b0}},
      '{FUNC_PUT,  CODE_BACKSPACE, 11'h000,  1'b1, '{11'd4,  8'h00, 1'b0}},
      '{FUNC_PUT,  CODE_NEWLINE,   11'h3FF,  1'b1, '{11'd80, 8'h00, 1'b0}},
      '{FUNC_PUT,  8'h7E,          11'h400,  1'b1, '{11'd81, 8'h00, 1'b0}},
      '{FUNC_PUT,  CODE_BACKSPACE, 11'h001,  1'b1, '{11'd80, 8'h00, 1'b0}},
      '{FUNC_PUT,  CODE_BACKSPACE, 11'h002,  1'b1, '{11'd79, 8'h00, 1'b0}},
      '{FUNC_READ, 8'h80,          11'd80,   1'b1, '{11'd79, 8'h00, 1'b0}},
      '{FUNC_PUT,  CODE_TAB,       11'h004,  1'b1, '{11'd81, 8'h00, 1'b0}},
      '{FUNC_PUT,  CODE_NEWLINE,   11'h008,  1'b1, '{11'd160, 8'h00, 1'b0}},
      '{FUNC_PUT,  8'hAA,          11'h010,  1'b0, '0},
      '{FUNC_PUT,  8'h55,          11'h020,  1'b0, '0},
      '{FUNC_READ, 8'h01,          11'd160,  1'b0, '0},
      '{FUNC_READ, 8'hFE,          11'h555,  1'b0, '0}
   };

   // Shift every row up by one and blank the bottom row.
   function automatic void scroll_screen();
      for (int i = 0; i < BOTTOM; i++)
         screen_mem[i] = screen_mem[i + COLUMNS];
      for (int i = BOTTOM; i < CELLS; i++)
         screen_mem[i] = '0;
      scroll_count++;
   endfunction

   // Apply one accepted request to the screen model and return the response it must give.
   function automatic console_resp_type console_apply(input console_cmd_type cmd);
      int unsigned      next_pos;
      console_resp_type resp;
      resp     = '0;
      next_pos = cur_pos;
      if (cmd.func == FUNC_READ) begin
         reads_seen++;
         if (cmd.read_cell < CELLS)
            resp.read_data = screen_mem[cmd.read_cell];
         else
            reads_beyond++;
      end else if (cmd.char_code == CODE_NEWLINE) begin
         next_pos = (cur_pos / COLUMNS + 1) * COLUMNS;
         if (next_pos >= CELLS) begin
            scroll_screen();
            resp.scrolled = 1'b1;
            next_pos      = BOTTOM;
         end
      end else if (cmd.char_code == CODE_BACKSPACE) begin
         // stop at the home cell
         if (cur_pos != 0) begin
            next_pos             = cur_pos - 1;
            screen_mem[next_pos] = '0;
         end
      end else begin
         if (cmd.char_code == CODE_TAB) begin
            screen_mem[cur_pos] = '0;
            // the second clear falls off the screen at the last cell: drop it
            if (cur_pos + 1 < CELLS)
               screen_mem[cur_pos + 1] = '0;
            else
               dropped_clears++;
            next_pos = cur_pos + 2;
         end else begin
            screen_mem[cur_pos] = cmd.char_code;
            next_pos            = cur_pos + 1;
         end
         if (next_pos >= CELLS) begin
            scroll_screen();
            resp.scrolled = 1'b1;
            next_pos      = BOTTOM;
         end
      end
      cur_pos          = CUR_W'(next_pos);
      resp.cursor_cell = cur_pos;
      return resp;
   endfunction

   // Any byte that is not a control code.
   function automatic logic [CHAR_W-1:0] ordinary_char();
      logic [CHAR_W-1:0] c;
      c = CHAR_W'($urandom_range(255));
      while (c == CODE_BACKSPACE || c == CODE_TAB || c == CODE_NEWLINE)
         c = CHAR_W'($urandom_range(255));
      return c;
   endfunction

   // Offer one request transaction. Entered and left at a falling edge; valid is
   // only lowered inside an idle gap, so back-to-back transactions keep it high.
   // On acceptance the screen model advances and the response it predicts, or the
   // typed one, joins the queue of responses due.
   task automatic offer_transaction(input logic [FUNC_W-1:0] func,
                                    input logic [CHAR_W-1:0] char_code,
                                    input logic [CUR_W-1:0]  read_cell,
                                    input logic              known = 1'b0,
                                    input console_resp_type  typed = '0);
      console_cmd_type  cmd;
      console_resp_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.func      <= func;
      req_chan.char_code <= char_code;
      req_chan.read_cell <= read_cell;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      cmd       = '{func, char_code, read_cell};
      predicted = console_apply(cmd);
      reports_due.push_back(known ? typed : predicted);
      items_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every response due has come back.
   task automatic hold_until_drained();
      req_chan.valid <= 1'b0;
      while (reports_due.size() != 0)
         @(negedge clock);
      @(negedge clock);
   endtask

   // Walk the cursor to a cell near the end of the screen, then put the given code
   // there. Newline from the bottom row scrolls back to its start, so overshoot is
   // cured the same way.
   task automatic walk_to_screen_end(input logic [CUR_W-1:0]  target,
                                     input logic [CHAR_W-1:0] final_code);
      while (cur_pos != target) begin
         if (cur_pos < BOTTOM || cur_pos > target)
            offer_transaction(FUNC_PUT, CODE_NEWLINE, CUR_W'($urandom_range(2047)));
         else
            offer_transaction(FUNC_PUT, ordinary_char(), CUR_W'($urandom_range(2047)));
      end
      offer_transaction(FUNC_PUT, final_code, CUR_W'($urandom_range(2047)));
   endtask

   // One random sequence: mostly text lines and read-backs, with bursts of control
   // codes, occasional walks to the end of the screen and some plain noise.
   task automatic random_sequence();
      int                kind;
      int                run_len;
      logic [CHAR_W-1:0] code;
      logic [CUR_W-1:0]  rd_cell;
      kind = $urandom_range(99);
      if (kind < 10) begin
         offer_transaction(FUNC_W'($urandom_range(1)), CHAR_W'($urandom_range(255)),
                           CUR_W'($urandom_range(2047)));
      end else if (kind < 50) begin
         // a line of text, now and then a long one that wraps past the row end
         run_len = ($urandom_range(9) == 0) ? $urandom_range(70, 90) : $urandom_range(30);
         repeat (run_len) begin
            case ($urandom_range(19))
               0:       code = CODE_TAB;
               1:       code = CODE_BACKSPACE;
               default: code = ordinary_char();
            endcase
            offer_transaction(FUNC_PUT, code, CUR_W'($urandom_range(2047)));
         end
         if ($urandom_range(3) != 0)
            offer_transaction(FUNC_PUT, CODE_NEWLINE, CUR_W'($urandom_range(2047)));
      end else if (kind < 72) begin
         // read back around the cursor row, elsewhere, and beyond the screen
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(9))
               0:       rd_cell = CUR_W'($urandom_range(2047, CELLS));
               1, 2:    rd_cell = CUR_W'($urandom_range(CELLS - 1));
               default: rd_cell = CUR_W'((cur_pos / COLUMNS) * COLUMNS
                                         + $urandom_range(COLUMNS - 1));
            endcase
            offer_transaction(FUNC_READ, CHAR_W'($urandom_range(255)), rd_cell);
         end
      end else if (kind < 80) begin
         repeat ($urandom_range(1, 6))
            offer_transaction(FUNC_PUT, CODE_BACKSPACE, CUR_W'($urandom_range(2047)));
      end else if (kind < 87) begin
         repeat ($urandom_range(1, 4))
            offer_transaction(FUNC_PUT, CODE_TAB, CUR_W'($urandom_range(2047)));
      end else if (kind < 98) begin
         // newline bursts reach the bottom row and scroll cheaply
         repeat ($urandom_range(1, 30))
            offer_transaction(FUNC_PUT, CODE_NEWLINE, CUR_W'($urandom_range(2047)));
      end else begin
         walk_to_screen_end(CUR_W'(CELLS - 1 - $urandom_range(2)),
                            $urandom_range(1) ? CODE_TAB : ordinary_char());
      end
   endtask

   // Receiver: drop ready at random for the current stall rate.
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);

   // Watchdog: count cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no transaction for %0d cycles, %0d responses still due",
               WATCHDOG_LIMIT, reports_due.size());
      $display("tb_text_console_cursor_engine failed");
      $finish;
   end

   // Response checker: compare each response, field by field, with the oldest one due.
   always @(posedge clock) begin : rsp_checker
      console_resp_type seen;
      console_resp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         seen = '{rsp_chan.cursor_cell, rsp_chan.read_data, rsp_chan.scrolled};
         if (reports_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("response %0d arrived with nothing due: cursor %0d data %0h scroll %0b",
                        rsps_seen, seen.cursor_cell, seen.read_data, seen.scrolled);
         end else begin
            want = reports_due.pop_front();
            if (seen.cursor_cell !== want.cursor_cell || seen.read_data !== want.read_data
                || seen.scrolled !== want.scrolled) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"response %0d mismatch: expected cursor %0d data %0h scroll %0b,",
                            " got cursor %0d data %0h scroll %0b"}, rsps_seen,
                           want.cursor_cell, want.read_data, want.scrolled,
                           seen.cursor_cell, seen.read_data, seen.scrolled);
            end
         end
         rsps_seen++;
      end
   end

   initial begin : stimulus
      int sender_pcts [4];
      int stall_pcts  [4];
      int phase_start;
      sender_pcts = '{0, 68, 0, 13};
      stall_pcts  = '{0, 0, 68, 13};

      // Drive every input to a known value and clear the screen model.
      req_chan.valid     = 1'b0;
      req_chan.func      = FUNC_PUT;
      req_chan.char_code = '0;
      req_chan.read_cell = '0;
      rsp_chan.ready     = 1'b0;
      for (int i = 0; i < CELLS; i++)
         screen_mem[i] = '0;
      cur_pos = '0;

      // Hold reset, then release it at a falling edge; the block then clears its store with ready low.
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed script, no idling on either side.
      foreach (directed_rows[i])
         offer_transaction(directed_rows[i].func, directed_rows[i].char_code,
                           directed_rows[i].read_cell, directed_rows[i].known,
                           directed_rows[i].want);
      hold_until_drained();

      // Random phases: no idling, sender gaps, receiver stalls, then both.
      // Each phase opens with a walk to the end of the screen so that a tab on
      // the last cell, a tab onto the last cell and a character there all occur.
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = sender_pcts[phase];
         rsp_stall_pct   = stall_pcts[phase];
         phase_start     = items_sent;
         case (phase)
            0:       walk_to_screen_end(CUR_W'(CELLS - 1), CODE_TAB);
            1:       walk_to_screen_end(CUR_W'(CELLS - 2), CODE_TAB);
            2:       walk_to_screen_end(CUR_W'(CELLS - 1), ordinary_char());
            default: walk_to_screen_end(CUR_W'(CELLS - 1 - $urandom_range(2)), CODE_NEWLINE);
         endcase
         while (items_sent - phase_start < PHASE_ITEMS)
            random_sequence();
         // sender pauses here until every response due has come back
         hold_until_drained();
      end

      // Keep watching for stray responses before the verdict.
      rsp_stall_pct = 0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d transactions, %0d responses: %0d reads (%0d beyond the screen),",
               items_sent, rsps_seen, reads_seen, reads_beyond);
      $display("  %0d scrolls, %0d tab clears dropped at the last cell, %0d mismatches",
               scroll_count, dropped_clears, mismatches);
      if (mismatches == 0 && reports_due.size() == 0) begin
         $display("tb_text_console_cursor_engine passed");
      end else begin
         $display("tb_text_console_cursor_engine failed");
      end
      $finish;
   end

endmodule

FILE: files.f
design/tcc_pkg.sv
design/tcc_chan_if.sv
design/tcc_ram.sv
design/tcc_ctrl.sv
design/tcc_datapath.sv
design/text_console_cursor_engine.sv
dv/tb_text_console_cursor_engine.sv
